// File: rtl/sjb_pkg.sv
`default_nettype none
package sjb_pkg;

  localparam int CAPACITY    = 32;
  localparam int NCELL       = CAPACITY + 1;
  localparam int DRAIN_LIMIT = 32;
  localparam int CNT_W       = $clog2(DRAIN_LIMIT + 1);

  // Wrap-around sequence distance limits (16-bit difference a - b)
  localparam logic [15:0] SEQ_HALF       = 16'd32768;
  localparam logic [15:0] FAR_AHEAD      = 16'd100;
  localparam logic [15:0] FAR_BEHIND_LIM = 16'd65436;

  // Request kinds
  localparam logic [1:0] REQ_PUSH  = 2'd0;
  localparam logic [1:0] REQ_POP   = 2'd1;
  localparam logic [1:0] REQ_DRAIN = 2'd2;

  // Result status codes
  localparam logic [2:0] ST_STORED  = 3'd0;
  localparam logic [2:0] ST_EVICTED = 3'd1;
  localparam logic [2:0] ST_DUP     = 3'd2;
  localparam logic [2:0] ST_STALE   = 3'd3;
  localparam logic [2:0] ST_DELIVER = 3'd4;
  localparam logic [2:0] ST_EMPTY   = 3'd5;

  // Register indexes
  localparam logic REG_TICK  = 1'b0;
  localparam logic REG_DELAY = 1'b1;

  typedef struct packed {
    logic [15:0] seq;
    logic [31:0] mask;
    logic [31:0] look_x;
    logic [31:0] look_y;
    logic [31:0] rtime;
  } entry_t;

  typedef struct packed {
    logic ins;
    logic shl;
  } cell_ctl_t;

endpackage
`default_nettype wire

// File: rtl/sjb_cell.sv
`default_nettype none
module sjb_cell (
  input  wire                 clk,
  input  wire                 rst_n,
  input  sjb_pkg::cell_ctl_t  ctl,
  input  wire [15:0]          key,
  input  sjb_pkg::entry_t     new_ent,
  input  sjb_pkg::entry_t     left_ent,
  input  wire                 left_vld,
  input  sjb_pkg::entry_t     right_ent,
  input  wire                 right_vld,
  input  wire                 prev_stop,
  output sjb_pkg::entry_t     ent,
  output logic                vld,
  output logic                stop,
  output logic                dup
);
  import sjb_pkg::*;

  entry_t      ent_r;
  logic        vld_r;
  logic [15:0] diff;
  logic        lt;
  logic        eq;
  logic        here;

  // Compare the key against this cell's entry
  assign diff = key - ent_r.seq;
  assign lt   = vld_r & (diff > SEQ_HALF);
  assign eq   = vld_r & (diff == 16'd0);
  assign here = ~prev_stop & (lt | ~vld_r);
  assign stop = prev_stop | lt | eq | ~vld_r;
  assign dup  = ~prev_stop & eq;

  assign ent = ent_r;
  assign vld = vld_r;

  // Occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (ctl.shl) begin
      vld_r <= right_vld;
    end else if (ctl.ins && here) begin
      vld_r <= 1'b1;
    end else if (ctl.ins && prev_stop) begin
      vld_r <= left_vld;
    end
  end

  // Payload: insert here, open a gap by taking the left neighbor, or close the front
  always_ff @(posedge clk) begin
    if (ctl.shl) begin
      ent_r <= right_ent;
    end else if (ctl.ins && here) begin
      ent_r <= new_ent;
    end else if (ctl.ins && prev_stop) begin
      ent_r <= left_ent;
    end
  end

endmodule
`default_nettype wire

// File: rtl/sequence_sorted_jitter_buffer.sv
`default_nettype none
// Channel  | dir | handshake               | payload
// in_      | in  | in_tvalid / in_tready   | tuser req_type, tdata packet fields
// out_     | out | out_tvalid / out_tready | tuser status, tdata entry, tlast last
// cfg_     | in  | APB psel/penable/pready | tick_period_ms @0x0, target_delay @0x4
// Push: S_PUSH posts the result after acceptance; S_EVICT follows when the list overflows
// and the front is evicted. Pop: S_MUL then S_CMP, or S_MUL alone on an empty list.
// Drain: S_MUL and S_CMP repeat for each delivered entry, up to DRAIN_LIMIT entries;
// S_MUL registers the product of the playout check and S_CMP does its add/compare.
// Any cycle that must post a result waits while the output register is full.
// rst_n is synchronous; it empties the cell row and clears the anchor.
module sequence_sorted_jitter_buffer (
  input  wire          clk,
  input  wire          rst_n,
  input  wire          in_tvalid,
  output logic         in_tready,
  input  wire  [1:0]   in_tuser,   // req_type
  input  wire  [143:0] in_tdata,   // seq_num, button_mask, look_x_bits, look_y_bits, time_ms
  output logic         out_tvalid,
  input  wire          out_tready,
  output logic [2:0]   out_tuser,  // status
  output logic [143:0] out_tdata,  // out_seq, out_mask, out_look_x, out_look_y, out_recv_time
  output logic         out_tlast,  // last
  input  wire          cfg_psel,
  input  wire          cfg_penable,
  input  wire          cfg_pwrite,
  input  wire  [2:0]   cfg_paddr,
  input  wire  [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);
  import sjb_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PUSH  = 3'd1;
  localparam logic [2:0] S_EVICT = 3'd2;
  localparam logic [2:0] S_MUL   = 3'd3;
  localparam logic [2:0] S_CMP   = 3'd4;

  logic [2:0]       state_r, state_nxt;
  logic [1:0]       req_r;
  entry_t           rq_r;
  logic [15:0]      anchor_seq_r;
  logic [31:0]      anchor_time_r;
  logic             anchored_r;
  logic [9:0]       tick_r;
  logic [15:0]      delay_r;
  logic [31:0]      prod_r;
  logic             pend_r;
  entry_t           pend_ent_r;
  logic [CNT_W-1:0] n_r;
  logic             out_valid_r;
  logic [2:0]       out_status_r;
  entry_t           out_ent_r;
  logic             out_last_r;

  cell_ctl_t        ctl;
  entry_t           ent  [NCELL];
  logic [NCELL-1:0] vld;
  logic [NCELL-1:0] dup;
  logic [NCELL:0]   stop;
  logic             dup_any;
  logic             out_free;
  logic             emit;
  logic [2:0]       emit_status;
  entry_t           emit_ent;
  logic             emit_last;
  logic [15:0]      adiff;
  logic [15:0]      pdiff;
  logic signed [27:0] prod_w;
  logic [31:0]      playout;
  logic             ready;
  logic             anchor_set;
  logic             take_pend;
  logic             cfg_wr;

  // Cell row: the insert-position and duplicate search ripples left to right
  assign stop[0] = 1'b0;
  genvar gi;
  for (gi = 0; gi < NCELL; gi++) begin : g_cell
    sjb_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .key       (rq_r.seq),
      .new_ent   (rq_r),
      .left_ent  ((gi == 0) ? entry_t'('0) : ent[(gi == 0) ? 0 : gi-1]),
      .left_vld  ((gi == 0) ? 1'b0 : vld[(gi == 0) ? 0 : gi-1]),
      .right_ent ((gi == NCELL-1) ? entry_t'('0) : ent[(gi == NCELL-1) ? gi : gi+1]),
      .right_vld ((gi == NCELL-1) ? 1'b0 : vld[(gi == NCELL-1) ? gi : gi+1]),
      .prev_stop (stop[gi]),
      .ent       (ent[gi]),
      .vld       (vld[gi]),
      .stop      (stop[gi+1]),
      .dup       (dup[gi])
    );
  end
  assign dup_any = |dup;

  // Handshakes
  assign in_tready  = (state_r == S_IDLE);
  assign out_free   = ~out_valid_r | out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {out_ent_r.rtime, out_ent_r.look_y, out_ent_r.look_x,
                       out_ent_r.mask, out_ent_r.seq};

  // Distances and playout time
  assign adiff   = rq_r.seq - anchor_seq_r;
  assign pdiff   = ent[0].seq - anchor_seq_r;
  assign prod_w  = $signed({pdiff > SEQ_HALF, pdiff}) * $signed({1'b0, tick_r});
  assign playout = anchor_time_r + {16'd0, delay_r} + prod_r;
  assign ready   = ($signed(rq_r.rtime) >= $signed(playout));

  // Sequencer
  always_comb begin
    state_nxt   = state_r;
    ctl         = '0;
    emit        = 1'b0;
    emit_status = ST_EMPTY;
    emit_ent    = '0;
    emit_last   = 1'b1;
    anchor_set  = 1'b0;
    take_pend   = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          if (in_tuser == REQ_PUSH) begin
            state_nxt = S_PUSH;
          end else if (in_tuser == REQ_POP || in_tuser == REQ_DRAIN) begin
            state_nxt = S_MUL;
          end
        end
      end
      S_PUSH: begin
        if (out_free) begin
          state_nxt = S_IDLE;
          emit      = 1'b1;
          if (anchored_r && adiff > SEQ_HALF && adiff < FAR_BEHIND_LIM) begin
            emit_status = ST_STALE;
          end else begin
            anchor_set = ~anchored_r | (adiff > FAR_AHEAD && adiff <= SEQ_HALF);
            if (dup_any) begin
              emit_status = ST_DUP;
            end else begin
              ctl.ins = 1'b1;
              if (vld[NCELL-2]) begin
                emit_status = ST_EVICTED;
                state_nxt   = S_EVICT;
              end else begin
                emit_status = ST_STORED;
              end
            end
          end
        end
      end
      S_EVICT: begin
        ctl.shl   = 1'b1;
        state_nxt = S_IDLE;
      end
      S_MUL: begin
        if (!vld[0] || n_r == CNT_W'(DRAIN_LIMIT)) begin
          if (out_free) begin
            emit        = 1'b1;
            emit_status = pend_r ? ST_DELIVER : ST_EMPTY;
            emit_ent    = pend_r ? pend_ent_r : entry_t'('0);
            state_nxt   = S_IDLE;
          end
        end else begin
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        if (out_free) begin
          if (!ready) begin
            emit        = 1'b1;
            emit_status = pend_r ? ST_DELIVER : ST_EMPTY;
            emit_ent    = pend_r ? pend_ent_r : entry_t'('0);
            state_nxt   = S_IDLE;
          end else if (req_r == REQ_POP) begin
            emit        = 1'b1;
            emit_status = ST_DELIVER;
            emit_ent    = ent[0];
            ctl.shl     = 1'b1;
            state_nxt   = S_IDLE;
          end else begin
            emit        = pend_r;
            emit_status = ST_DELIVER;
            emit_ent    = pend_ent_r;
            emit_last   = 1'b0;
            take_pend   = 1'b1;
            ctl.shl     = 1'b1;
            state_nxt   = S_MUL;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      anchored_r  <= 1'b0;
      anchor_seq_r  <= 16'd0;
      anchor_time_r <= 32'd0;
      pend_r      <= 1'b0;
      n_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= emit | (out_valid_r & ~out_tready);
      if (anchor_set) begin
        anchored_r    <= 1'b1;
        anchor_seq_r  <= rq_r.seq;
        anchor_time_r <= rq_r.rtime;
      end
      if (state_r == S_IDLE) begin
        pend_r <= 1'b0;
        n_r    <= '0;
      end else if (take_pend) begin
        pend_r <= 1'b1;
        n_r    <= n_r + CNT_W'(1);
      end
    end
  end

  // Request, product and result payload
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_tvalid) begin
      req_r         <= in_tuser;
      rq_r.seq      <= in_tdata[15:0];
      rq_r.mask     <= in_tdata[47:16];
      rq_r.look_x   <= in_tdata[79:48];
      rq_r.look_y   <= in_tdata[111:80];
      rq_r.rtime    <= in_tdata[143:112];
    end
    prod_r <= {{4{prod_w[27]}}, prod_w};
    if (take_pend) begin
      pend_ent_r <= ent[0];
    end
    if (emit) begin
      out_status_r <= emit_status;
      out_ent_r    <= emit_ent;
      out_last_r   <= emit_last;
    end
  end

  // Configuration registers
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r  <= 10'd50;
      delay_r <= 16'd0;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == REG_TICK) begin
        tick_r <= cfg_pwdata[9:0];
      end else begin
        delay_r <= cfg_pwdata[15:0];
      end
    end
  end
  assign cfg_prdata = (cfg_paddr[2] == REG_DELAY) ? {16'd0, delay_r}
                                                  : {22'd0, tick_r};

  // Occupied cells always form an unbroken run from the front
  a_contig: assert property (@(posedge clk) disable iff (!rst_n)
    ((vld + NCELL'(1)) & vld) == '0)
    else $error("cell row has a gap");

  // The overflow cell is only ever filled for one cycle, right before eviction
  a_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    vld[NCELL-1] |-> (state_r == S_EVICT))
    else $error("overflow cell occupied outside eviction");

  // A held entry never survives the end of a request
  a_pend: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && $past(state_r) == S_IDLE) |-> !pend_r)
    else $error("pending entry left behind");

  // Drain never exceeds its delivery limit
  a_limit: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= CNT_W'(DRAIN_LIMIT))
    else $error("drain count past limit");

endmodule
`default_nettype wire

// File: sim/sequence_sorted_jitter_buffer_tb.sv
`default_nettype none
module sequence_sorted_jitter_buffer_tb;
  import sjb_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;

  // Register addresses and a request code the block ignores
  localparam logic [2:0] ADDR_TICK  = 3'd0;
  localparam logic [2:0] ADDR_DELAY = 3'd4;
  localparam logic [2:0] ADDR_ODD   = 3'd2;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  typedef struct {
    logic [2:0]  status;
    logic [15:0] seq;
    logic [31:0] mask;
    logic [31:0] look_x;
    logic [31:0] look_y;
    logic [31:0] rtime;
    logic        last;
  } playout_t;

  int mismatches = 0;

  task automatic report(input string msg);
    $display("mismatch: %s", msg);
    mismatches++;
  endtask

  // Scoreboard: a software copy of the sorted list that predicts each result
  class jitter_scoreboard;
    logic [15:0] q_seq[$];
    logic [31:0] q_mask[$];
    logic [31:0] q_lx[$];
    logic [31:0] q_ly[$];
    logic [31:0] q_time[$];
    logic [15:0] anchor_seq;
    logic [31:0] anchor_time;
    bit          anchored;
    logic [9:0]  tick;
    logic [15:0] delay;
    playout_t    pending[$];

    function new();
      anchored = 0; anchor_seq = 0; anchor_time = 0; tick = 50; delay = 0;
    endfunction

    function automatic int wrap_dist(logic [15:0] a, logic [15:0] b);
      logic [15:0] d;
      int r;
      d = a - b;
      r = d;
      if (d > 16'd32768) r -= 65536;
      return r;
    endfunction

    function automatic bit head_ready(logic [31:0] now);
      logic [31:0] po;
      logic [31:0] d;
      d = 32'(wrap_dist(q_seq[0], anchor_seq));
      po = anchor_time + {16'd0, delay} + d * {22'd0, tick};
      return $signed(now) >= $signed(po);
    endfunction

    // Remove the oldest entry from the list
    function automatic void drop_head();
      q_seq.delete(0); q_mask.delete(0); q_lx.delete(0);
      q_ly.delete(0); q_time.delete(0);
    endfunction

    function automatic void post(logic [2:0] st, bit from_head, bit lst);
      playout_t p;
      p.status = st; p.last = lst;
      if (from_head) begin
        p.seq = q_seq[0]; p.mask = q_mask[0];
        p.look_x = q_lx[0]; p.look_y = q_ly[0];
        p.rtime = q_time[0];
        drop_head();
      end else begin
        p.seq = 0; p.mask = 0; p.look_x = 0; p.look_y = 0; p.rtime = 0;
      end
      pending.insert(pending.size(), p);
    endfunction

    function automatic logic [2:0] insert_packet(logic [15:0] s, logic [31:0] m,
                                                 logic [31:0] lx, logic [31:0] ly,
                                                 logic [31:0] t);
      int pos, d;
      if (!anchored) begin
        anchor_seq = s; anchor_time = t; anchored = 1;
      end else begin
        d = wrap_dist(s, anchor_seq);
        if (d > 100) begin
          anchor_seq = s; anchor_time = t;
        end else if (d < -100) return ST_STALE;
      end
      pos = q_seq.size();
      for (int i = 0; i < q_seq.size(); i++) begin
        d = wrap_dist(s, q_seq[i]);
        if (d == 0) return ST_DUP;
        if (d < 0) begin
          pos = i;
          break;
        end
      end
      q_seq.insert(pos, s); q_mask.insert(pos, m); q_lx.insert(pos, lx);
      q_ly.insert(pos, ly); q_time.insert(pos, t);
      if (q_seq.size() > CAPACITY) begin
        drop_head();
        return ST_EVICTED;
      end
      return ST_STORED;
    endfunction

    // Note an accepted input transaction
    function automatic void note_request(logic [1:0] req, logic [143:0] d);
      int n;
      n = 0;
      if (req == REQ_PUSH)
        post(insert_packet(d[15:0], d[47:16], d[79:48], d[111:80], d[143:112]), 0, 1);
      else if (req == REQ_POP) begin
        if (q_seq.size() > 0 && head_ready(d[143:112])) post(ST_DELIVER, 1, 1);
        else post(ST_EMPTY, 0, 1);
      end else if (req == REQ_DRAIN) begin
        while (n < DRAIN_LIMIT && q_seq.size() > 0 && head_ready(d[143:112])) begin
          post(ST_DELIVER, 1, 0);
          n++;
        end
        if (n == 0) post(ST_EMPTY, 0, 1);
        else pending[pending.size() - 1].last = 1;
      end
    endfunction

    // Check an accepted result transaction
    task automatic check_result(logic [2:0] st, logic [143:0] d, logic lst);
      playout_t p;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result status %0d", st));
        return;
      end
      p = pending[0];
      pending.delete(0);
      if (st !== p.status) report($sformatf("status %0d exp %0d", st, p.status));
      if (d[15:0] !== p.seq) report($sformatf("seq %h exp %h", d[15:0], p.seq));
      if (d[47:16] !== p.mask) report($sformatf("mask %h exp %h", d[47:16], p.mask));
      if (d[79:48] !== p.look_x) report($sformatf("look_x %h exp %h", d[79:48], p.look_x));
      if (d[111:80] !== p.look_y) report($sformatf("look_y %h exp %h", d[111:80], p.look_y));
      if (d[143:112] !== p.rtime) report($sformatf("time %h exp %h", d[143:112], p.rtime));
      if (lst !== p.last)
        report($sformatf("last %b exp %b", lst, p.last));
    endtask
  endclass

  logic         clk = 0;
  logic         rst_n = 0;
  logic         in_tvalid = 0;
  logic         in_tready;
  logic [1:0]   in_tuser = 0;    // req_type
  logic [143:0] in_tdata = 0;    // seq_num, button_mask, look_x_bits, look_y_bits, time_ms
  logic         out_tvalid;
  logic         out_tready = 0;
  logic [2:0]   out_tuser;       // status
  logic [143:0] out_tdata;       // out_seq, out_mask, out_look_x, out_look_y, out_recv_time
  logic         out_tlast;
  logic         cfg_psel = 0;
  logic         cfg_penable = 0;
  logic         cfg_pwrite = 0;
  logic [2:0]   cfg_paddr = 0;
  logic [31:0]  cfg_pwdata = 0;
  logic [31:0]  cfg_prdata;
  logic         cfg_pready;

  sequence_sorted_jitter_buffer dut (.*);

  jitter_scoreboard sb = new();
  int  send_idle_pct = 8;
  int  recv_idle_pct = 85;
  bit  hold_off = 0;
  int  cycles = 0;
  logic [15:0] seq_base = 16'd1000;
  logic [31:0] now_ms = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  // Cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[sequence_sorted_jitter_buffer] ERROR");
      $finish;
    end
  end

  // Result side: sample at rising edge, pick ready at falling edge
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tuser, out_tdata, out_tlast);
  end
  always @(negedge clk) begin
    out_tready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic cfg_write(input logic [2:0] addr, input logic [31:0] val);
    @(negedge clk);
    cfg_psel <= 1; cfg_penable <= 0; cfg_pwrite <= 1; cfg_paddr <= addr; cfg_pwdata <= val;
    @(negedge clk);
    cfg_penable <= 1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (addr[2] == REG_TICK) sb.tick = val[9:0];
    else sb.delay = val[15:0];
    @(negedge clk);
    cfg_psel <= 0; cfg_penable <= 0; cfg_pwrite <= 0;
  endtask

  task automatic send(input logic [1:0] req, input logic [15:0] s, input logic [31:0] t);
    logic [143:0] d;
    d = {t, $urandom(), $urandom(), $urandom(), s};
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    in_tvalid <= 1; in_tuser <= req; in_tdata <= d;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_request(req, d);
    @(negedge clk);
    in_tvalid <= 0;
  endtask

  task automatic settle();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  // Mostly well-formed traffic around a moving base, some noise
  task automatic random_item();
    int r;
    r = $urandom_range(99);
    now_ms += $urandom_range(40);
    if (r < 55) begin
      if ($urandom_range(19) == 0) seq_base = 16'($urandom());
      else if ($urandom_range(9) == 0) seq_base += 16'($urandom_range(300));
      send(REQ_PUSH, seq_base + 16'($urandom_range(80)) - 16'd30, now_ms);
    end else if (r < 75) send(REQ_POP, 16'($urandom()),
                              ($urandom_range(9) == 0) ? $urandom() : now_ms + 300);
    else if (r < 95) send(REQ_DRAIN, 16'($urandom()),
                          ($urandom_range(9) == 0) ? 32'h7fffffff : now_ms + 500);
    else send(REQ_UNUSED, 16'($urandom()), $urandom());
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;
    repeat (3) @(posedge clk);

    // Directed: empty requests, anchoring, dups, stale, rebase, extremes
    send(REQ_POP, 0, 0);
    send(REQ_DRAIN, 0, 32'h80000000);
    send(REQ_PUSH, 16'hfff0, 32'h7fffff00);
    send(REQ_PUSH, 16'hfff0, 32'h7fffff00);
    send(REQ_PUSH, 16'h0005, 32'h7fffff10);
    send(REQ_PUSH, 16'hff00, 0);
    send(REQ_PUSH, 16'hffef, 32'hffffffff);
    send(REQ_UNUSED, 16'hffff, 32'hffffffff);
    send(REQ_POP, 0, 32'h80000000);
    send(REQ_POP, 0, 32'h7fffffff);
    send(REQ_PUSH, 16'h0100, 32'h00000064);
    send(REQ_PUSH, 16'h0100, 32'h00000064);
    send(REQ_DRAIN, 0, 32'h7fffffff);
    settle();
    cfg_write(ADDR_TICK, 32'd1);
    cfg_write(ADDR_DELAY, 32'd60000);
    cfg_write(ADDR_ODD, 32'hffffffff);
    // Overflow with the new packet itself the oldest
    for (int i = 0; i < 33; i++) send(REQ_PUSH, 16'd2000 + 16'(i + 1), 32'd10);
    send(REQ_PUSH, 16'd2000, 32'd10);
    send(REQ_DRAIN, 0, 32'd100000);
    settle();
    cfg_write(ADDR_TICK, 32'd1000);
    cfg_write(ADDR_DELAY, 32'd0);

    // Receiver hold-off: fill the block until it stalls
    hold_off = 1;
    fork
      begin
        repeat (400) @(posedge clk);
        hold_off = 0;
      end
      for (int i = 0; i < 12; i++) random_item();
    join
    settle();

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 8 : (ph == 1) ? 85 : 0;
      recv_idle_pct = (ph == 0) ? 85 : (ph == 1) ? 8 : 0;
      for (int i = 0; i < 66; i++) random_item();
      settle();
      cfg_write(ADDR_TICK, (ph == 0) ? 32'h3ff : (ph == 1) ? 32'd0 : 32'd50);
      cfg_write(ADDR_DELAY, (ph == 0) ? 32'hffff : 32'($urandom_range(500)));
    end

    settle();
    if (mismatches == 0 && sb.pending.size() == 0)
      $display("[sequence_sorted_jitter_buffer] OK");
    else
      $display("[sequence_sorted_jitter_buffer] ERROR");
    $finish;
  end
endmodule
`default_nettype wire
